/* src/gpio_ex_pkg.sv */
// Shared types, codes and pin masks for the GPIO port with edge interrupts.
package gpio_ex_pkg;

  localparam int unsigned PinCount = 16;

  localparam int unsigned AfLoPins = (PinCount > 8) ? 8 : PinCount;
  localparam int unsigned AfHiPins = (PinCount > 8) ? (PinCount - 8) : 0;

  localparam logic [15:0] PinMask  = 16'((64'd1 << PinCount) - 64'd1);
  localparam logic [31:0] PairMask = 32'((64'd1 << (2 * PinCount)) - 64'd1);
  localparam logic [31:0] AfLoMask = 32'((64'd1 << (4 * AfLoPins)) - 64'd1);
  localparam logic [31:0] AfHiMask = 32'((64'd1 << (4 * AfHiPins)) - 64'd1);

  localparam logic [1:0] ModeOutput = 2'b01;

  typedef enum logic [1:0] {
    CmdRead   = 2'd0,
    CmdWrite  = 2'd1,
    CmdSample = 2'd2,
    CmdNop    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    RegMode    = 4'd0,
    RegOtype   = 4'd1,
    RegSpeed   = 4'd2,
    RegPull    = 4'd3,
    RegIdr     = 4'd4,
    RegOdr     = 4'd5,
    RegAfl     = 4'd6,
    RegAfh     = 4'd7,
    RegRise    = 4'd8,
    RegFall    = 4'd9,
    RegMask    = 4'd10,
    RegPending = 4'd11
  } reg_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  reg_select;
    logic [31:0] write_data;
    logic [15:0] pin_levels;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] pad_drive;
    logic [15:0] pad_enable;
    logic        irq;
  } result_t;

endpackage

/* src/gpio_port_with_edge_interrupts_core.sv */
// Top level of the 16-pin GPIO port with edge interrupts.
// Each transfer in is a register read, a register write or a pin sample, and gives
// exactly one transfer out carrying read data (zero unless a read), the pad drive
// levels, the pad output enables and the masked interrupt line, all as they stand
// after the item. The port takes one item per cycle while the output side is not
// stalled; a result passes through the input register and then the result
// register, with the register update done between them. A stall on the output
// side holds the result register and then the input register.
module gpio_port_with_edge_interrupts_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  reg_select_i,
  input  logic [31:0] write_data_i,
  input  logic [15:0] pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic [15:0] pad_drive_o,
  output logic [15:0] pad_enable_o,
  output logic        irq_o
);

  logic                 in_valid_q;
  gpio_ex_pkg::item_t   item_q;
  logic                 out_valid_q;
  gpio_ex_pkg::result_t res_q;
  gpio_ex_pkg::result_t res_d;
  logic                 out_free;
  logic                 advance;
  logic                 in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  gpio_ex_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .exec_i   (advance),
    .item_i   (item_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.command    <= command_i;
      item_q.reg_select <= reg_select_i;
      item_q.write_data <= write_data_i;
      item_q.pin_levels <= pin_levels_i;
    end
    if (advance) res_q <= res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = res_q.read_data;
  assign pad_drive_o  = res_q.pad_drive;
  assign pad_enable_o = res_q.pad_enable;
  assign irq_o        = res_q.irq;

endmodule

/* src/gpio_ex_regs.sv */
// Register file of the port: bus decode, edge detection and result views.
module gpio_ex_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                exec_i,
  input  gpio_ex_pkg::item_t  item_i,
  output gpio_ex_pkg::result_t result_o
);

  logic [31:0] mode_q, mode_d;
  logic [15:0] otype_q, otype_d;
  logic [31:0] speed_q, speed_d;
  logic [31:0] pull_q, pull_d;
  logic [15:0] idr_q, idr_d;
  logic [15:0] odr_q, odr_d;
  logic [31:0] afl_q, afl_d;
  logic [31:0] afh_q, afh_d;
  logic [15:0] rise_q, rise_d;
  logic [15:0] fall_q, fall_d;
  logic [15:0] mask_q, mask_d;
  logic [15:0] pend_q, pend_d;

  gpio_ex_pkg::cmd_e cmd;
  gpio_ex_pkg::reg_e sel;
  logic [15:0] wr_half;
  logic [15:0] now_lv;
  logic [15:0] edges;
  logic [31:0] rd_data;
  logic [15:0] enables;

  assign cmd     = gpio_ex_pkg::cmd_e'(item_i.command);
  assign sel     = gpio_ex_pkg::reg_e'(item_i.reg_select);
  assign wr_half = item_i.write_data[15:0] & gpio_ex_pkg::PinMask;
  assign now_lv  = item_i.pin_levels & gpio_ex_pkg::PinMask;
  assign edges   = (now_lv & ~idr_q & rise_q) | (~now_lv & idr_q & fall_q);

  always_comb begin
    mode_d  = mode_q;
    otype_d = otype_q;
    speed_d = speed_q;
    pull_d  = pull_q;
    idr_d   = idr_q;
    odr_d   = odr_q;
    afl_d   = afl_q;
    afh_d   = afh_q;
    rise_d  = rise_q;
    fall_d  = fall_q;
    mask_d  = mask_q;
    pend_d  = pend_q;
    rd_data = '0;
    unique case (cmd)
      gpio_ex_pkg::CmdRead: begin
        unique case (sel)
          gpio_ex_pkg::RegMode:    rd_data = mode_q;
          gpio_ex_pkg::RegOtype:   rd_data = {16'd0, otype_q};
          gpio_ex_pkg::RegSpeed:   rd_data = speed_q;
          gpio_ex_pkg::RegPull:    rd_data = pull_q;
          gpio_ex_pkg::RegIdr:     rd_data = {16'd0, idr_q};
          gpio_ex_pkg::RegOdr:     rd_data = {16'd0, odr_q};
          gpio_ex_pkg::RegAfl:     rd_data = afl_q;
          gpio_ex_pkg::RegAfh:     rd_data = afh_q;
          gpio_ex_pkg::RegRise:    rd_data = {16'd0, rise_q};
          gpio_ex_pkg::RegFall:    rd_data = {16'd0, fall_q};
          gpio_ex_pkg::RegMask:    rd_data = {16'd0, mask_q};
          gpio_ex_pkg::RegPending: rd_data = {16'd0, pend_q};
          default:                 rd_data = '0;
        endcase
      end
      gpio_ex_pkg::CmdWrite: begin
        unique case (sel)
          gpio_ex_pkg::RegMode:    mode_d  = item_i.write_data & gpio_ex_pkg::PairMask;
          gpio_ex_pkg::RegOtype:   otype_d = wr_half;
          gpio_ex_pkg::RegSpeed:   speed_d = item_i.write_data & gpio_ex_pkg::PairMask;
          gpio_ex_pkg::RegPull:    pull_d  = item_i.write_data & gpio_ex_pkg::PairMask;
          gpio_ex_pkg::RegOdr:     odr_d   = wr_half;
          gpio_ex_pkg::RegAfl:     afl_d   = item_i.write_data & gpio_ex_pkg::AfLoMask;
          gpio_ex_pkg::RegAfh:     afh_d   = item_i.write_data & gpio_ex_pkg::AfHiMask;
          gpio_ex_pkg::RegRise:    rise_d  = wr_half;
          gpio_ex_pkg::RegFall:    fall_d  = wr_half;
          gpio_ex_pkg::RegMask:    mask_d  = wr_half;
          // write one to clear
          gpio_ex_pkg::RegPending: pend_d  = pend_q & ~wr_half;
          default: ;  // input data is read-only, unknown selects drop
        endcase
      end
      gpio_ex_pkg::CmdSample: begin
        idr_d  = now_lv;
        pend_d = pend_q | edges;
      end
      default: ;
    endcase
  end

  // Results show the state after the item.
  always_comb begin
    enables = '0;
    for (int unsigned i = 0; i < gpio_ex_pkg::PinCount; i++) begin
      enables[i] = (mode_d[2*i +: 2] == gpio_ex_pkg::ModeOutput);
    end
  end

  assign result_o.read_data  = rd_data;
  assign result_o.pad_drive  = odr_d;
  assign result_o.pad_enable = enables;
  assign result_o.irq        = |(pend_d & mask_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      otype_q <= '0;
      speed_q <= '0;
      pull_q  <= '0;
      idr_q   <= '0;
      odr_q   <= '0;
      afl_q   <= '0;
      afh_q   <= '0;
      rise_q  <= '0;
      fall_q  <= '0;
      mask_q  <= '0;
      pend_q  <= '0;
    end else if (exec_i) begin
      mode_q  <= mode_d;
      otype_q <= otype_d;
      speed_q <= speed_d;
      pull_q  <= pull_d;
      idr_q   <= idr_d;
      odr_q   <= odr_d;
      afl_q   <= afl_d;
      afh_q   <= afh_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
      mask_q  <= mask_d;
      pend_q  <= pend_d;
    end
  end

endmodule

/* src/gpio_ex_checker.sv */
// Port-level checks for the GPIO port core, bound to the top level.
module gpio_ex_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] read_data_o,
  input logic [15:0] pad_drive_o,
  input logic [15:0] pad_enable_o,
  input logic        irq_o
);

  // Stall the input only while a result is backed up.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A taken item reaches the output once the output side lets it through.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("taken item did not reach the output");

  // Hold a blocked result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_data_o)
      && $stable(pad_drive_o) && $stable(pad_enable_o) && $stable(irq_o)))
    else $error("blocked result changed");

  // No result right out of reset.
  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind gpio_port_with_edge_interrupts_core gpio_ex_checker u_chk (.*);
